[sv/fdor_pkg.sv]
// ----------------------------------------------------------------------------
// fdor_pkg
// Shared types, pattern tables and helpers for the dot-operator rewriter.
// ----------------------------------------------------------------------------
package fdor_pkg;

  localparam int DEF_WINDOW_DEPTH = 7;
  localparam int NUM_PAT          = 12;
  localparam int PAT_MAX_LEN      = 7;

  typedef logic [7:0] char_t;
  typedef logic [2:0] plen_t;
  typedef logic [3:0] col_t;

  localparam col_t  DEF_COLUMNS_SKIPPED = 4'd6;
  localparam char_t CH_NUL   = 8'h00;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_QUOTE = 8'h27;

  // Number of result characters a head rewrite produces
  typedef enum logic [1:0] {
    RES_NONE,
    RES_ONE,
    RES_TWO
  } fdor_nres_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_REWRITE,
    S_EMIT2,
    S_TERM
  } fdor_state_t;

  // Controller to datapath
  typedef struct packed {
    logic push;
    logic col_inc;
    logic consume;
    logic load_first;
    logic load_second;
    logic load_term;
  } fdor_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       empty;
    logic       one_short;
    logic       col_lt_skip;
    logic       slot_free;
    logic       rest_empty;
    fdor_nres_t head_nres;
  } fdor_sts_t;

  // Pattern texts, lower case, padded with NUL
  localparam char_t PAT_TEXT [NUM_PAT][PAT_MAX_LEN] = '{
    '{".", "l", "t", ".", CH_NUL, CH_NUL, CH_NUL},
    '{".", "g", "t", ".", CH_NUL, CH_NUL, CH_NUL},
    '{".", "l", "e", ".", CH_NUL, CH_NUL, CH_NUL},
    '{".", "g", "e", ".", CH_NUL, CH_NUL, CH_NUL},
    '{".", "e", "q", ".", CH_NUL, CH_NUL, CH_NUL},
    '{".", "n", "e", ".", CH_NUL, CH_NUL, CH_NUL},
    '{".", "o", "r", ".", CH_NUL, CH_NUL, CH_NUL},
    '{".", "a", "n", "d", ".", CH_NUL, CH_NUL},
    '{".", "x", "o", "r", ".", CH_NUL, CH_NUL},
    '{".", "n", "o", "t", ".", CH_NUL, CH_NUL},
    '{".", "t", "r", "u", "e", ".", CH_NUL},
    '{".", "f", "a", "l", "s", "e", "."}
  };

  localparam plen_t PAT_LEN [NUM_PAT] = '{
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd6, 3'd7
  };

  localparam char_t PAT_SUB0 [NUM_PAT] = '{
    "<", ">", "<", ">", "=", "<", "|", "&", "^", "!", "-", "0"
  };

  localparam char_t PAT_SUB1 [NUM_PAT] = '{
    CH_NUL, CH_NUL, "=", "=", CH_NUL, ">", CH_NUL, CH_NUL, CH_NUL, CH_NUL, "1", CH_NUL
  };

  localparam fdor_nres_t PAT_NRES [NUM_PAT] = '{
    RES_ONE, RES_ONE, RES_TWO, RES_TWO, RES_ONE, RES_TWO,
    RES_ONE, RES_ONE, RES_ONE, RES_ONE, RES_TWO, RES_ONE
  };

  // ASCII upper case to lower case, everything else unchanged
  function automatic char_t fold(input char_t c);
    if (c >= "A" && c <= "Z") begin
      return c | 8'h20;
    end
    return c;
  endfunction

endpackage

[sv/fdor_ctrl.sv]
// ----------------------------------------------------------------------------
// fdor_ctrl
// Sequencer: takes transactions, steps head rewrites, the end-of-line drain
// and the terminator.
// ----------------------------------------------------------------------------
module fdor_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_end_of_line,
  input  fdor_pkg::fdor_sts_t sts,
  output fdor_pkg::fdor_cmd_t cmd
);
  import fdor_pkg::*;

  fdor_state_t state_r, state_nxt;
  logic        flush_r, flush_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      flush_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      flush_r <= flush_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    flush_nxt = flush_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_end_of_line) begin
            flush_nxt = 1'b1;
            state_nxt = sts.empty ? S_TERM : S_REWRITE;
          end else if (sts.col_lt_skip) begin
            cmd.col_inc = 1'b1;
          end else begin
            cmd.push = 1'b1;
            if (sts.one_short) begin
              state_nxt = S_REWRITE;
            end
          end
        end
      end
      S_REWRITE: begin
        unique case (sts.head_nres)
          RES_NONE: begin
            cmd.consume = 1'b1;
          end
          RES_ONE: begin
            if (sts.slot_free) begin
              cmd.load_first = 1'b1;
              cmd.consume    = 1'b1;
            end
          end
          RES_TWO: begin
            if (sts.slot_free) begin
              cmd.load_first = 1'b1;
              state_nxt      = S_EMIT2;
            end
          end
          default: begin
            cmd.consume = 1'b1;
          end
        endcase
      end
      S_EMIT2: begin
        if (sts.slot_free) begin
          cmd.load_second = 1'b1;
          cmd.consume     = 1'b1;
        end
      end
      S_TERM: begin
        if (sts.slot_free) begin
          cmd.load_term = 1'b1;
          flush_nxt     = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // after a head is consumed: keep draining, terminate, or go back for input
    if (cmd.consume) begin
      if (!flush_r) begin
        state_nxt = S_IDLE;
      end else if (sts.rest_empty) begin
        state_nxt = S_TERM;
      end else begin
        state_nxt = S_REWRITE;
      end
    end
  end

  // second symbol only follows a two-symbol match
  a_emit2_two: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT2) |-> (sts.head_nres == RES_TWO))
    else $error("second symbol state without a two-symbol match");

endmodule

[sv/fdor_datapath.sv]
// ----------------------------------------------------------------------------
// fdor_datapath
// Look-ahead window, pattern matcher, line state and output register.
// ----------------------------------------------------------------------------
module fdor_datapath #(
  parameter int WINDOW_DEPTH = fdor_pkg::DEF_WINDOW_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_wdata,
  input  logic [7:0]          in_char,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_char,
  output logic                out_line_done,
  input  fdor_pkg::fdor_cmd_t cmd,
  output fdor_pkg::fdor_sts_t sts
);
  import fdor_pkg::*;

  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int IDX_W  = $clog2(WINDOW_DEPTH);

  char_t             win_r   [WINDOW_DEPTH];
  char_t             win_nxt [WINDOW_DEPTH];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  col_t              col_r, col_nxt;
  col_t              skip_r, skip_nxt;
  logic              quote_r, quote_nxt;
  logic              ovld_r, ovld_nxt;
  char_t             ochar_r, ochar_nxt;
  logic              odone_r, odone_nxt;

  // head decode
  char_t      hd_c0, hd_c1;
  plen_t      hd_len;
  fdor_nres_t hd_nres;
  logic       hd_toggle;

  always_comb begin
    logic hit;
    logic ok;
    char_t c;
    hit       = 1'b0;
    c         = win_r[0];
    hd_c0     = c;
    hd_c1     = CH_NUL;
    hd_len    = 3'd1;
    hd_toggle = 1'b0;
    if ((c == CH_SPACE && quote_r) || c == CH_QUOTE || c > CH_SPACE) begin
      hd_nres = RES_ONE;
    end else begin
      hd_nres = RES_NONE;
    end
    // patterns tried in table order, first hit wins
    for (int p = 0; p < NUM_PAT; p++) begin
      ok = (FILL_W'(PAT_LEN[p]) <= fill_r);
      for (int j = 0; j < PAT_MAX_LEN; j++) begin
        if (j < int'(PAT_LEN[p]) && fold(win_r[j]) != PAT_TEXT[p][j]) begin
          ok = 1'b0;
        end
      end
      if (!hit && ok) begin
        hit     = 1'b1;
        hd_c0   = PAT_SUB0[p];
        hd_c1   = PAT_SUB1[p];
        hd_len  = PAT_LEN[p];
        hd_nres = PAT_NRES[p];
      end
    end
    if (!hit && c == CH_QUOTE) begin
      hd_toggle = 1'b1;
    end
  end

  // status to the controller
  always_comb begin
    sts.empty       = (fill_r == '0);
    sts.one_short   = (fill_r == FILL_W'(WINDOW_DEPTH - 1));
    sts.col_lt_skip = (col_r < skip_r);
    sts.slot_free   = !ovld_r || out_ready;
    sts.rest_empty  = (fill_r == FILL_W'(hd_len));
    sts.head_nres   = hd_nres;
  end

  // window: append at fill, shift out a consumed head
  always_comb begin
    win_nxt = win_r;
    if (cmd.push) begin
      win_nxt[fill_r[IDX_W-1:0]] = in_char;
    end
    if (cmd.consume) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        for (int n = 1; n <= PAT_MAX_LEN; n++) begin
          if (hd_len == plen_t'(n) && i + n < WINDOW_DEPTH) begin
            win_nxt[i] = win_r[i + n];
          end
        end
      end
    end
  end

  // line state, config and output register
  always_comb begin
    fill_nxt  = fill_r;
    col_nxt   = col_r;
    quote_nxt = quote_r;
    skip_nxt  = cfg_we ? cfg_wdata : skip_r;
    ovld_nxt  = out_ready ? 1'b0 : ovld_r;
    ochar_nxt = ochar_r;
    odone_nxt = odone_r;
    if (cmd.push) begin
      fill_nxt = fill_r + 1'b1;
    end
    if (cmd.col_inc) begin
      col_nxt = col_r + 1'b1;
    end
    if (cmd.consume) begin
      fill_nxt = fill_r - FILL_W'(hd_len);
      if (hd_toggle) begin
        quote_nxt = ~quote_r;
      end
    end
    if (cmd.load_first) begin
      ovld_nxt  = 1'b1;
      ochar_nxt = hd_c0;
      odone_nxt = 1'b0;
    end
    if (cmd.load_second) begin
      ovld_nxt  = 1'b1;
      ochar_nxt = hd_c1;
      odone_nxt = 1'b0;
    end
    if (cmd.load_term) begin
      ovld_nxt  = 1'b1;
      ochar_nxt = CH_NUL;
      odone_nxt = 1'b1;
      fill_nxt  = '0;
      col_nxt   = '0;
      quote_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      col_r   <= '0;
      skip_r  <= DEF_COLUMNS_SKIPPED;
      quote_r <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      fill_r  <= fill_nxt;
      col_r   <= col_nxt;
      skip_r  <= skip_nxt;
      quote_r <= quote_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r   <= win_nxt;
    ochar_r <= ochar_nxt;
    odone_r <= odone_nxt;
  end

  assign out_valid     = ovld_r;
  assign out_char      = ochar_r;
  assign out_line_done = odone_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW_DEPTH))
    else $error("window fill beyond depth");

  a_load_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_first || cmd.load_second || cmd.load_term) |-> sts.slot_free)
    else $error("output register overwritten before taken");

  a_consume_fill: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.consume |-> (FILL_W'(hd_len) <= fill_r))
    else $error("consume larger than window fill");

  a_term_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_term |=> (fill_r == '0 && !quote_r && col_r == '0))
    else $error("line state not cleared after terminator");

endmodule

[sv/fortran_dot_operator_rewriter_core.sv]
// A character is taken in S_IDLE; a result is registered and shown from
//   the cycle after the head rewrite that made it.
// Throughput: one character per cycle in S_IDLE; a push that fills the window
//   is followed by a head rewrite (plus S_EMIT2 when it gives two symbols).
//   End of line: taken in S_IDLE, then a head rewrite per head, then S_TERM.
// out_ready low stalls these steps. Reset: rst_n synchronous, active low; skip = 6.
// ----------------------------------------------------------------------------
// fortran_dot_operator_rewriter_core
// Top level: rewrites dot operators of a source line into short symbols.
// ----------------------------------------------------------------------------
module fortran_dot_operator_rewriter_core #(
  parameter int WINDOW_DEPTH = fdor_pkg::DEF_WINDOW_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_end_of_line,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_line_done
);
  import fdor_pkg::*;

  fdor_cmd_t cmd;
  fdor_sts_t sts;

  fdor_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_end_of_line (in_end_of_line),
    .sts            (sts),
    .cmd            (cmd)
  );

  fdor_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_char       (in_char),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char      (out_char),
    .out_line_done (out_line_done),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

[test/tb_fortran_dot_operator_rewriter_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fortran_dot_operator_rewriter_core
// Self-checking bench for the dot-operator rewriter. A short table of source
// lines covers every operator, quoting, short lines, extreme bytes and a skip
// change mid-line. Random lines built from operator, name, quote and noise
// tokens follow. Every result transaction is checked against the table's
// symbols or a bench line-rewrite model, under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_fortran_dot_operator_rewriter_core;
  import fdor_pkg::*;

  localparam int    WIN          = DEF_WINDOW_DEPTH;
  localparam int    NUM_OPS      = 12;
  localparam int    NUM_DIR      = 16;
  localparam int    RANDOM_CHARS = 185;
  localparam int    SETTLE_CYC   = 8;
  localparam int    LONG_HOLD    = 80;
  localparam char_t NUL_STANDIN  = 8'h01;   // table strings cannot hold NUL

  // One result transaction
  typedef struct packed {
    char_t ch;
    logic  done;
  } sym_t;

  // One directed source line
  typedef struct {
    int    skip;
    string text;
    int    mid_at;     // character index where the skip changes, -1 for none
    int    mid_skip;
    bit    typed;      // expected symbols given below
    string symbols;
  } line_case_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [3:0] cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_char;
  logic       in_end_of_line;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_char;
  logic       out_line_done;

  // Operator spellings and their replacements, in match order
  string op_text [NUM_OPS] = '{".lt.", ".gt.", ".le.", ".ge.", ".eq.", ".ne.",
                               ".or.", ".and.", ".xor.", ".not.", ".true.", ".false."};
  string op_subst [NUM_OPS] = '{"<", ">", "<=", ">=", "=", "<>",
                                "|", "&", "^", "!", "-1", "0"};

  line_case_t dir_tab [NUM_DIR] = '{
    '{6,  "C    1x = a .LT. b",          -1, 0, 1'b1, "x=a<b"},
    '{0,  "IF(A.gt.B.and.C.Ne.D)",       -1, 0, 1'b1, "IF(A>B&C<>D)"},
    '{0,  "x.le.y.ge.z.eq.w.or.v.xor.u", -1, 0, 1'b1, "x<=y>=z=w|v^u"},
    '{0,  "L=.NOT..TRUE..oR..False.",    -1, 0, 1'b1, "L=!-1|0"},
    '{0,  "PRINT 'a .lt. b  c'",         -1, 0, 1'b1, "PRINT'a < b  c'"},
    '{0,  "'open q",                     -1, 0, 1'b1, "'open q"},
    '{0,  " a b",                        -1, 0, 1'b1, "ab"},
    '{0,  "\001A\177\200\377 z\t",       -1, 0, 1'b1, "A\177\200\377z"},
    '{15, "ABCDEFG",                     -1, 0, 1'b1, ""},
    '{15, "",                            -1, 0, 1'b1, ""},
    '{15, "ABCDEFGHIJKLMNO.",            -1, 0, 1'b1, "."},
    '{0,  "a..eq..b.lt",                 -1, 0, 1'b0, ""},
    '{3,  "xyz.ne.x.true",               -1, 0, 1'b0, ""},
    '{6,  "abcdefghi .ge. j",             3, 2, 1'b0, ""},
    '{1,  "x=.false.",                   -1, 0, 1'b0, ""},
    '{0,  "q=.AnD..xOr.'a'.GE.'b",       -1, 0, 1'b0, ""}
  };

  // Model state
  char_t win [WIN];
  int    win_fill;
  col_t  col_cnt;
  col_t  skip_cols;
  bit    in_quote;

  sym_t  sym_q [$];    // symbols of the latest character
  sym_t  exp_q [$];    // symbols awaited from the block
  char_t line_buf [$];
  sym_t  want;

  bit use_model;
  bit quiet;
  bit hold_req;
  int err_count;
  int chars_sent;
  int lines_sent;
  int syms_checked;
  int cfg_writes;

  fortran_dot_operator_rewriter_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char        (in_char),
    .in_end_of_line (in_end_of_line),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .out_line_done  (out_line_done)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------- model
  function automatic char_t lower_case(input char_t c);
    if (c >= "A" && c <= "Z") begin
      return c + 8'd32;
    end
    return c;
  endfunction

  function automatic bit op_at_head(input int p);
    int n;
    int i;
    n = op_text[p].len();
    if (n > win_fill) begin
      return 1'b0;
    end
    for (i = 0; i < n; i++) begin
      if (lower_case(win[i]) != char_t'(op_text[p][i])) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic pop_window(input int n);
    int i;
    if (n > win_fill) begin
      n = win_fill;
    end
    for (i = 0; i + n < win_fill; i++) begin
      win[i] = win[i + n];
    end
    win_fill -= n;
  endtask

  // Rewrite whatever stands at the head of the window
  task automatic rewrite_head();
    int    p;
    int    j;
    char_t c;
    if (win_fill == 0) begin
      return;
    end
    for (p = 0; p < NUM_OPS; p++) begin
      if (op_at_head(p)) begin
        for (j = 0; j < op_subst[p].len(); j++) begin
          sym_q.push_back({char_t'(op_subst[p][j]), 1'b0});
        end
        pop_window(op_text[p].len());
        return;
      end
    end
    c = win[0];
    if (c == CH_SPACE && in_quote) begin
      sym_q.push_back({c, 1'b0});
    end else if (c == CH_QUOTE) begin
      in_quote = !in_quote;
      sym_q.push_back({c, 1'b0});
    end else if (c > CH_SPACE) begin
      sym_q.push_back({c, 1'b0});
    end
    pop_window(1);
  endtask

  // Symbols caused by one accepted character or end of line
  task automatic rewrite_char(input char_t c, input bit eol);
    if (eol) begin
      while (win_fill > 0) begin
        rewrite_head();
      end
      sym_q.push_back({CH_NUL, 1'b1});
      col_cnt  = '0;
      in_quote = 1'b0;
    end else if (col_cnt < skip_cols) begin
      col_cnt = col_cnt + 4'd1;
    end else begin
      while (win_fill >= WIN) begin
        rewrite_head();
      end
      win[win_fill] = c;
      win_fill++;
      while (win_fill >= WIN) begin
        rewrite_head();
      end
    end
  endtask

  // ------------------------------------------------------------- drivers
  // Offer one transaction; leaves valid high on return
  task automatic send_item(input char_t c, input bit eol);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_char        = c;
    in_end_of_line = eol;
    do @(posedge clk); while (!in_ready);
    rewrite_char(c, eol);
    if (use_model) begin
      foreach (sym_q[i]) exp_q.push_back(sym_q[i]);
    end
    sym_q.delete();
    chars_sent++;
    @(negedge clk);
  endtask

  // Register write once the block has drained
  task automatic write_skip(input int v);
    in_valid = 1'b0;
    while (exp_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
    cfg_wdata = col_t'(v);
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
    skip_cols = col_t'(v);
    cfg_writes++;
  endtask

  task automatic send_line(input int mid_at, input int mid_skip);
    foreach (line_buf[i]) begin
      if (i == mid_at) begin
        write_skip(mid_skip);
      end
      send_item(line_buf[i], 1'b0);
    end
    send_item(char_t'($urandom_range(0, 255)), 1'b1);
    lines_sent++;
  endtask

  // Random line: skipped columns, then operator, name, quote and noise tokens
  task automatic build_line();
    int    body_len;
    int    r;
    int    p;
    int    i;
    int    k;
    char_t c;
    line_buf.delete();
    for (i = 0; i < int'(skip_cols); i++) begin
      line_buf.push_back(char_t'($urandom_range(0, 255)));
    end
    body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 16);
    while (line_buf.size() < int'(skip_cols) + body_len) begin
      r = $urandom_range(0, 9);
      case (r)
        0, 1, 2, 3: begin
          // operator in mixed case, now and then with one character spoilt
          p = $urandom_range(0, NUM_OPS - 1);
          k = ($urandom_range(0, 5) == 0) ? $urandom_range(0, op_text[p].len() - 1) : -1;
          for (i = 0; i < op_text[p].len(); i++) begin
            c = char_t'(op_text[p][i]);
            if (c >= "a" && c <= "z" && $urandom_range(0, 1)) begin
              c = c - 8'd32;
            end
            if (i == k) begin
              c = char_t'($urandom_range(8'h21, 8'h7e));
            end
            line_buf.push_back(c);
          end
        end
        4, 5: begin
          k = $urandom_range(1, 4);
          for (i = 0; i < k; i++) begin
            c = char_t'($urandom_range("a", "z"));
            if ($urandom_range(0, 1)) begin
              c = c - 8'd32;
            end
            line_buf.push_back(c);
          end
        end
        6:       line_buf.push_back(CH_SPACE);
        7:       line_buf.push_back(CH_QUOTE);
        8:       line_buf.push_back(char_t'($urandom_range(0, 255)));
        default: line_buf.push_back(".");
      endcase
    end
  endtask

  // ------------------------------------------------------------ receiver
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // long hold-off so the window fills and the input stalls
        hold_req  = 1'b0;
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      stall = quiet ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // ------------------------------------------------------------- checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (exp_q.size() == 0) begin
        $error("unexpected transaction: out_char %02h out_line_done %b",
               out_char, out_line_done);
        err_count++;
      end else begin
        want = exp_q.pop_front();
        syms_checked++;
        if (out_char !== want.ch) begin
          $error("out_char mismatch: expected %02h, got %02h", want.ch, out_char);
          err_count++;
        end
        if (out_line_done !== want.done) begin
          $error("out_line_done mismatch: expected %b, got %b", want.done, out_line_done);
          err_count++;
        end
      end
    end
  end

  // ------------------------------------------------------------ stimulus
  initial begin
    int    t;
    int    i;
    int    ln;
    int    start;
    char_t c;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_char        = '0;
    in_end_of_line = 1'b0;
    win_fill       = 0;
    col_cnt        = '0;
    skip_cols      = DEF_COLUMNS_SKIPPED;
    in_quote       = 1'b0;
    use_model      = 1'b1;
    quiet          = 1'b0;
    hold_req       = 1'b0;
    err_count      = 0;
    chars_sent     = 0;
    lines_sent     = 0;
    syms_checked   = 0;
    cfg_writes     = 0;
    foreach (win[w]) win[w] = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed lines
    for (t = 0; t < NUM_DIR; t++) begin
      if (dir_tab[t].skip != int'(skip_cols)) begin
        write_skip(dir_tab[t].skip);
      end
      use_model = !dir_tab[t].typed;
      if (dir_tab[t].typed) begin
        for (i = 0; i < dir_tab[t].symbols.len(); i++) begin
          exp_q.push_back({char_t'(dir_tab[t].symbols[i]), 1'b0});
        end
        exp_q.push_back({CH_NUL, 1'b1});
      end
      line_buf.delete();
      for (i = 0; i < dir_tab[t].text.len(); i++) begin
        c = char_t'(dir_tab[t].text[i]);
        line_buf.push_back((c == NUL_STANDIN) ? CH_NUL : c);
      end
      send_line(dir_tab[t].mid_at, dir_tab[t].mid_skip);
    end
    use_model = 1'b1;

    // random lines; skip mostly small, sometimes at the extremes
    start = chars_sent;
    ln    = 0;
    while (chars_sent - start < RANDOM_CHARS) begin
      if (ln % 4 == 3) begin
        case ($urandom_range(0, 9))
          0:       write_skip(0);
          1:       write_skip(15);
          default: write_skip($urandom_range(0, 4));
        endcase
      end
      if (ln == 3) begin
        hold_req = 1'b1;
      end
      quiet = (ln >= 6 && ln < 9);
      build_line();
      send_line(-1, 0);
      ln++;
    end
    quiet    = 1'b0;
    in_valid = 1'b0;

    // drain
    while (exp_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("summary: %0d lines, %0d characters sent, %0d symbols checked",
             lines_sent, chars_sent, syms_checked);
    $display("summary: %0d skip writes, one long output hold-off", cfg_writes);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
